// File: rtl/source_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Source tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STOK_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, disabled during reset.
`define STOK_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

// File: rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Types, codes and character classes shared by the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_ZERO, M_DEC, M_HEX, M_BIN, M_LT, M_GT, M_EQ,
        M_BANG, M_AMP, M_PIPE, M_ERR
    } mode_t;

    localparam logic [1:0] K_LEXEME = 2'd0;
    localparam logic [1:0] K_TOKEN  = 2'd1;
    localparam logic [1:0] K_ERROR  = 2'd2;

    localparam logic E_UNEXPECTED = 1'b0;
    localparam logic E_BANG       = 1'b1;

    localparam logic [5:0] T_EOF      = 6'd0;
    localparam logic [5:0] T_NUM      = 6'd1;
    localparam logic [5:0] T_ID       = 6'd2;
    localparam logic [5:0] T_RET      = 6'd3;
    localparam logic [5:0] T_GLB      = 6'd4;
    localparam logic [5:0] T_IF       = 6'd5;
    localparam logic [5:0] T_ELSE     = 6'd6;
    localparam logic [5:0] T_LOOP     = 6'd7;
    localparam logic [5:0] T_BREAK    = 6'd8;
    localparam logic [5:0] T_PLUS     = 6'd9;
    localparam logic [5:0] T_MINUS    = 6'd10;
    localparam logic [5:0] T_DIV      = 6'd11;
    localparam logic [5:0] T_MUL      = 6'd12;
    localparam logic [5:0] T_LE       = 6'd13;
    localparam logic [5:0] T_SHL      = 6'd14;
    localparam logic [5:0] T_LT       = 6'd15;
    localparam logic [5:0] T_GE       = 6'd16;
    localparam logic [5:0] T_SHR      = 6'd17;
    localparam logic [5:0] T_GT       = 6'd18;
    localparam logic [5:0] T_COMMA    = 6'd19;
    localparam logic [5:0] T_EQEQ     = 6'd20;
    localparam logic [5:0] T_EQ       = 6'd21;
    localparam logic [5:0] T_NE       = 6'd22;
    localparam logic [5:0] T_LPAREN   = 6'd23;
    localparam logic [5:0] T_RPAREN   = 6'd24;
    localparam logic [5:0] T_LBRACKET = 6'd25;
    localparam logic [5:0] T_RBRACKET = 6'd26;
    localparam logic [5:0] T_LBRACE   = 6'd27;
    localparam logic [5:0] T_RBRACE   = 6'd28;
    localparam logic [5:0] T_AT       = 6'd29;
    localparam logic [5:0] T_PERCENT  = 6'd30;
    localparam logic [5:0] T_ANDAND   = 6'd31;
    localparam logic [5:0] T_AMP      = 6'd32;
    localparam logic [5:0] T_OROR     = 6'd33;
    localparam logic [5:0] T_PIPE     = 6'd34;
    localparam logic [5:0] T_TILDE    = 6'd35;
    localparam logic [5:0] T_HASH     = 6'd36;
    localparam logic [5:0] T_CARET    = 6'd37;
    localparam logic [5:0] T_SEMI     = 6'd38;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [39:0] KW_RET   = 40'h00_0072_6574;
    localparam logic [39:0] KW_GLB   = 40'h00_0067_6C62;
    localparam logic [39:0] KW_IF    = 40'h00_0000_6966;
    localparam logic [39:0] KW_ELSE  = 40'h00_656C_7365;
    localparam logic [39:0] KW_LOOP  = 40'h00_6C6F_6F70;
    localparam logic [39:0] KW_BREAK = 40'h62_7265_616B;

    localparam int unsigned FIFO_DEPTH = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text;
        logic [5:0] ttype;
        logic       err;
    } rec_meta_t;

    function automatic rec_meta_t mk_meta(input logic [1:0] kind, input logic [7:0] text,
                                          input logic [5:0] ttype, input logic err);
        rec_meta_t m;
        m.kind  = kind;
        m.text  = text;
        m.ttype = ttype;
        m.err   = err;
        return m;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_xdigit(input logic [7:0] b);
        return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic is_wordc(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == "_";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    // Keyword lookup on the last five word bytes; ID when nothing matches.
    function automatic logic [5:0] kw_type(input logic [39:0] kb);
        logic [5:0] t;
        t = T_ID;
        if (kb == KW_RET)   t = T_RET;
        if (kb == KW_GLB)   t = T_GLB;
        if (kb == KW_IF)    t = T_IF;
        if (kb == KW_ELSE)  t = T_ELSE;
        if (kb == KW_LOOP)  t = T_LOOP;
        if (kb == KW_BREAK) t = T_BREAK;
        return t;
    endfunction

    // Single-byte operators; T_EOF means the byte is not one.
    function automatic logic [5:0] single_op(input logic [7:0] b);
        logic [5:0] t;
        case (b)
            "+":     t = T_PLUS;
            "-":     t = T_MINUS;
            "/":     t = T_DIV;
            "*":     t = T_MUL;
            ",":     t = T_COMMA;
            "(":     t = T_LPAREN;
            ")":     t = T_RPAREN;
            "[":     t = T_LBRACKET;
            "]":     t = T_RBRACKET;
            "{":     t = T_LBRACE;
            "}":     t = T_RBRACE;
            "@":     t = T_AT;
            "%":     t = T_PERCENT;
            "~":     t = T_TILDE;
            "#":     t = T_HASH;
            "^":     t = T_CARET;
            ";":     t = T_SEMI;
            default: t = T_EOF;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/stok_scan.sv
// ----------------------------------------------------------------------------
// stok_scan
// Scanner state and per-byte record generation; up to two records per item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_tokenizer_assert.svh"

module stok_scan #(
    parameter int unsigned LINE_BITS   = 24,
    parameter int unsigned LENGTH_BITS = 16,
    parameter int unsigned ENT_W       = 17 + LINE_BITS + LENGTH_BITS + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       char_byte,
    input  wire logic             end_of_input,
    output logic      [1:0]       push_cnt,
    output logic      [ENT_W-1:0] push_ent0,
    output logic      [ENT_W-1:0] push_ent1
);
    import stok_pkg::*;

    mode_t                  mode_reg, mode_next;
    logic [39:0]            kb_reg, kb_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   sl_reg, sl_next;

    logic                   in_end;
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic                   consumed;
    logic                   app, tok, bang_err;
    logic [5:0]             tok_type;
    logic [LENGTH_BITS-1:0] tok_len;
    logic [5:0]             op_t;

    logic                   a_v, b_v;
    rec_meta_t              meta_a, meta_b;
    logic [LINE_BITS-1:0]   line_a, line_b;
    logic [LENGTH_BITS-1:0] len_a, len_b;

    assign in_end  = end_of_input || (char_byte == 8'd0);
    assign b       = in_end ? 8'd0 : char_byte;
    assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + LENGTH_BITS'(1);
    assign op_t    = single_op(b);

    always_comb
    begin
        mode_next = mode_reg;
        kb_next   = kb_reg;
        cnt_next  = cnt_reg;
        line_next = line_reg;
        sl_next   = sl_reg;
        consumed  = 1'b1;
        app       = 1'b0;
        tok       = 1'b0;
        bang_err  = 1'b0;
        tok_type  = T_EOF;
        tok_len   = '0;
        a_v       = 1'b0;
        b_v       = 1'b0;
        meta_a    = mk_meta(K_LEXEME, 8'd0, T_EOF, E_UNEXPECTED);
        meta_b    = mk_meta(K_LEXEME, 8'd0, T_EOF, E_UNEXPECTED);
        line_a    = sl_reg;
        line_b    = line_reg;
        len_a     = '0;
        len_b     = '0;

        if (accept && mode_reg != M_ERR)
        begin
            // finish or extend the pending token
            case (mode_reg)
                M_WORD:
                begin
                    if (is_wordc(b))
                        app = 1'b1;
                    else
                    begin
                        tok      = 1'b1;
                        tok_type = (cnt_reg <= LENGTH_BITS'(5)) ? kw_type(kb_reg) : T_ID;
                        tok_len  = cnt_reg;
                        consumed = 1'b0;
                    end
                end
                M_ZERO:
                begin
                    if (b == "x" || b == "X")
                    begin
                        app       = 1'b1;
                        mode_next = M_HEX;
                    end
                    else if (b == "b" || b == "B")
                    begin
                        app       = 1'b1;
                        mode_next = M_BIN;
                    end
                    else if (is_digit(b))
                    begin
                        app       = 1'b1;
                        mode_next = M_DEC;
                    end
                    else
                    begin
                        tok      = 1'b1;
                        tok_type = T_NUM;
                        tok_len  = cnt_reg;
                        consumed = 1'b0;
                    end
                end
                M_DEC, M_HEX, M_BIN:
                begin
                    if ((mode_reg == M_DEC && is_digit(b)) ||
                        (mode_reg == M_HEX && is_xdigit(b)) ||
                        (mode_reg == M_BIN && (b == "0" || b == "1")))
                        app = 1'b1;
                    else
                    begin
                        tok      = 1'b1;
                        tok_type = T_NUM;
                        tok_len  = cnt_reg;
                        consumed = 1'b0;
                    end
                end
                M_LT:
                begin
                    tok = 1'b1;
                    if (b == "<")
                        tok_type = T_SHL;
                    else if (b == "=")
                        tok_type = T_LE;
                    else
                    begin
                        tok_type = T_LT;
                        consumed = 1'b0;
                    end
                end
                M_GT:
                begin
                    tok = 1'b1;
                    if (b == ">")
                        tok_type = T_SHR;
                    else if (b == "=")
                        tok_type = T_GE;
                    else
                    begin
                        tok_type = T_GT;
                        consumed = 1'b0;
                    end
                end
                M_EQ:
                begin
                    tok      = 1'b1;
                    tok_type = (b == "=") ? T_EQEQ : T_EQ;
                    consumed = (b == "=");
                end
                M_AMP:
                begin
                    tok      = 1'b1;
                    tok_type = (b == "&") ? T_ANDAND : T_AMP;
                    consumed = (b == "&");
                end
                M_PIPE:
                begin
                    tok      = 1'b1;
                    tok_type = (b == "|") ? T_OROR : T_PIPE;
                    consumed = (b == "|");
                end
                M_BANG:
                begin
                    if (b == "=")
                    begin
                        tok      = 1'b1;
                        tok_type = T_NE;
                    end
                    else
                        bang_err = 1'b1;
                end
                default:
                    consumed = 1'b0;
            endcase

            if (app)
            begin
                cnt_next = cnt_inc;
                kb_next  = {kb_reg[31:0], b};
                a_v      = 1'b1;
                meta_a   = mk_meta(K_LEXEME, b, T_EOF, E_UNEXPECTED);
                len_a    = cnt_inc;
            end
            if (tok)
            begin
                mode_next = M_IDLE;
                a_v       = 1'b1;
                meta_a    = mk_meta(K_TOKEN, 8'd0, tok_type, E_UNEXPECTED);
                len_a     = tok_len;
            end
            if (bang_err)
            begin
                mode_next = M_ERR;
                a_v       = 1'b1;
                meta_a    = mk_meta(K_ERROR, b, T_EOF, E_BANG);
            end

            if (in_end)
            begin
                if (mode_next != M_ERR)
                begin
                    b_v       = 1'b1;
                    meta_b    = mk_meta(K_TOKEN, 8'd0, T_EOF, E_UNEXPECTED);
                    mode_next = M_IDLE;
                    kb_next   = '0;
                    cnt_next  = '0;
                    line_next = LINE_BITS'(1);
                    sl_next   = LINE_BITS'(1);
                end
            end
            else
            begin
                if (!consumed)
                begin
                    // byte starts anew
                    mode_next = M_IDLE;
                    sl_next   = line_reg;
                    cnt_next  = '0;
                    kb_next   = '0;
                    if (is_space(b))
                        b_v = 1'b0;
                    else if (is_alpha(b) || b == "_" || is_digit(b))
                    begin
                        if (is_digit(b))
                            mode_next = (b == "0") ? M_ZERO : M_DEC;
                        else
                            mode_next = M_WORD;
                        cnt_next = LENGTH_BITS'(1);
                        kb_next  = {32'd0, b};
                        b_v      = 1'b1;
                        meta_b   = mk_meta(K_LEXEME, b, T_EOF, E_UNEXPECTED);
                        len_b    = LENGTH_BITS'(1);
                    end
                    else
                    begin
                        case (b)
                            "<":     mode_next = M_LT;
                            ">":     mode_next = M_GT;
                            "=":     mode_next = M_EQ;
                            "!":     mode_next = M_BANG;
                            "&":     mode_next = M_AMP;
                            "|":     mode_next = M_PIPE;
                            default:
                            begin
                                b_v = 1'b1;
                                if (op_t != T_EOF)
                                    meta_b = mk_meta(K_TOKEN, 8'd0, op_t, E_UNEXPECTED);
                                else
                                begin
                                    meta_b    = mk_meta(K_ERROR, b, T_EOF, E_UNEXPECTED);
                                    mode_next = M_ERR;
                                end
                            end
                        endcase
                    end
                end
                if (b == CH_LF && mode_next != M_ERR && line_reg != '1)
                    line_next = line_reg + LINE_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            kb_reg   <= '0;
            cnt_reg  <= '0;
            line_reg <= LINE_BITS'(1);
            sl_reg   <= LINE_BITS'(1);
        end
        else
        begin
            mode_reg <= mode_next;
            kb_reg   <= kb_next;
            cnt_reg  <= cnt_next;
            line_reg <= line_next;
            sl_reg   <= sl_next;
        end
    end

    // compact to slot 0 first; the last slot written carries the last mark
    assign push_cnt  = {1'b0, a_v} + {1'b0, b_v};
    assign push_ent0 = a_v ? {meta_a, line_a, len_a, !b_v} : {meta_b, line_b, len_b, 1'b1};
    assign push_ent1 = {meta_b, line_b, len_b, 1'b1};

    `STOK_ASSERT_IMPL(a_err_silent, clk, rst_n, accept && mode_reg == M_ERR, push_cnt == 2'd0)
    `STOK_ASSERT_IMPL(a_line_nonzero, clk, rst_n, 1'b1, line_reg != '0)
    `STOK_ASSERT_NEXT(a_eof_restart, clk, rst_n, accept && in_end && mode_next != M_ERR, mode_reg == M_IDLE && line_reg == LINE_BITS'(1))

endmodule

`default_nettype wire

// File: rtl/stok_fifo.sv
// ----------------------------------------------------------------------------
// stok_fifo
// Four-entry record queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_tokenizer_assert.svh"

module stok_fifo #(
    parameter int unsigned WIDTH = 58
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       wr_cnt,
    input  wire logic [WIDTH-1:0] wr_ent0,
    input  wire logic [WIDTH-1:0] wr_ent1,
    output logic                  full2,
    output logic                  rd_valid,
    input  wire logic             rd_stall,
    output logic      [WIDTH-1:0] rd_ent
);
    import stok_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_p1;
    logic             pop;

    assign pop       = rd_valid && !rd_stall;
    assign rd_valid  = (count_reg != '0);
    assign rd_ent    = mem[rd_ptr_reg];
    assign full2     = (count_reg > CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(wr_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
            mem[wr_ptr_reg] <= wr_ent0;
        if (wr_cnt == 2'd2)
            mem[wr_ptr_p1] <= wr_ent1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `STOK_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `STOK_ASSERT_IMPL(a_no_overrun, clk, rst_n, wr_cnt != 2'd0, (4'(count_reg) + 4'(wr_cnt)) <= 4'(FIFO_DEPTH))
    `STOK_ASSERT_NEXT(a_hold_count, clk, rst_n, !pop && wr_cnt == 2'd0, count_reg == $past(count_reg))

endmodule

`default_nettype wire

// File: rtl/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Byte-stream lexer producing lexeme, token and error records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one source byte per item, with
//   end_of_input; a zero byte also ends the source.
//   Output channel (out_valid / out_stall): one record per item; an input
//   item gives zero, one or two records, the last flagged by last_record.
//   Records of an item are registered into the record queue as it is
//   accepted. Throughput: one input item per cycle while each gives at most
//   one record and out_stall is low; items giving two records are bounded by
//   the one-record-per-cycle output, buffered in a four-entry record queue.
//   in_stall rises when the queue holds more than two records, so a stall
//   on the output side fills the queue and then stalls the input side.
//   After an error no further records are given until reset.
//   Reset (rst_n low, asynchronous) empties the queue and returns the
//   scanner to idle on line one; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer #(
    parameter int unsigned LINE_BITS   = 24,
    parameter int unsigned LENGTH_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             char_byte,
    input  wire logic                   end_of_input,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [1:0]             record_kind,
    output logic      [7:0]             text_char,
    output logic      [5:0]             token_class,
    output logic      [LINE_BITS-1:0]   token_line,
    output logic      [LENGTH_BITS-1:0] token_length,
    output logic                        error_code,
    output logic                        last_record
);
    import stok_pkg::*;

    localparam int unsigned ENT_W = $bits(rec_meta_t) + LINE_BITS + LENGTH_BITS + 1;

    logic             accept;
    logic [1:0]       push_cnt;
    logic [ENT_W-1:0] push_ent0, push_ent1, rd_ent;
    rec_meta_t        meta;

    assign accept = in_valid && !in_stall;

    stok_scan #(
        .LINE_BITS   (LINE_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .ENT_W       (ENT_W)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_byte    (char_byte),
        .end_of_input (end_of_input),
        .push_cnt     (push_cnt),
        .push_ent0    (push_ent0),
        .push_ent1    (push_ent1)
    );

    stok_fifo #(
        .WIDTH (ENT_W)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (push_cnt),
        .wr_ent0  (push_ent0),
        .wr_ent1  (push_ent1),
        .full2    (in_stall),
        .rd_valid (out_valid),
        .rd_stall (out_stall),
        .rd_ent   (rd_ent)
    );

    assign {meta, token_line, token_length, last_record} = rd_ent;
    assign record_kind = meta.kind;
    assign text_char   = meta.text;
    assign token_class = meta.ttype;
    assign error_code  = meta.err;

endmodule

`default_nettype wire
